// ===== hw/rtl/pmhb_pkg.sv =====
// shared constants, types and the arctangent table of the polar max-height binner
// used by the cordic unit and the top level; no dependencies
`default_nettype none
package pmhb_pkg;

  localparam int MAX_SECTORS = 64;
  localparam int MAX_RINGS   = 32;
  localparam int ANGLE_BITS  = 16;

  localparam int SEC_W  = $clog2(MAX_SECTORS);
  localparam int RING_W = $clog2(MAX_RINGS);
  localparam int ADDR_W = SEC_W + RING_W;
  localparam int DEPTH  = MAX_SECTORS * MAX_RINGS;
  localparam int NS_W   = $clog2(MAX_SECTORS + 1);
  localparam int NR_W   = $clog2(MAX_RINGS + 1);
  localparam int ITER_W = $clog2(ANGLE_BITS);
  localparam int H_W    = 23;

  // output status codes
  localparam logic [1:0] STAT_BIN  = 2'd0;
  localparam logic [1:0] STAT_DROP = 2'd1;
  localparam logic [1:0] STAT_READ = 2'd2;
  localparam logic [1:0] STAT_OOR  = 2'd3;

  // register indexes
  localparam logic [2:0] CFG_CENTER_X     = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y     = 3'd1;
  localparam logic [2:0] CFG_MAX_RADIUS   = 3'd2;
  localparam logic [2:0] CFG_SECTOR_COUNT = 3'd3;
  localparam logic [2:0] CFG_RING_COUNT   = 3'd4;

  typedef struct packed {
    logic                  done;
    logic [ANGLE_BITS:0]   angle;
  } pmhb_ang_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2F9;  5'd15: v = 32'h0000517C;
      5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A2F;  5'd19: v = 32'h00000517;
      5'd20: v = 32'h0000028B;  5'd21: v = 32'h00000145;
      5'd22: v = 32'h000000A2;  5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000028;  5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000002;  5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/polar_max_height_binner_unit.sv =====
// polar max-height binner: bins points into a sector-by-ring grid of running maxima
// depends on pmhb_pkg, pmhb_ram and pmhb_cordic
// flow: a read checks its cell, then reads and clears it if in range; a point is squared,
// summed and range-checked, then its ring search runs while the cordic normalizes, rotates
// and rounds, and the point waits for the cordic angle before its cell is updated
// throughput: one item at a time, set by the serial ring search and the cordic loop
// reset: a clearing pass writes zero to all 2048 grid cells, with no item accepted
// meanwhile; registers take their reset values at once
`default_nettype none
module polar_max_height_binner_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_func,
  input  wire logic signed [23:0]           in_point_x,
  input  wire logic signed [23:0]           in_point_y,
  input  wire logic signed [23:0]           in_point_z,
  input  wire logic [5:0]                   in_read_sector,
  input  wire logic [4:0]                   in_read_ring,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_status,
  output logic [5:0]                        out_cell_sector,
  output logic [4:0]                        out_cell_ring,
  output logic [22:0]                       out_cell_height,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [23:0]                  cfg_data
);
  import pmhb_pkg::*;

  typedef enum logic [13:0] {
    ST_CLR   = 14'b00000000000001,
    ST_IDLE  = 14'b00000000000010,
    ST_RDCHK = 14'b00000000000100,
    ST_SQ    = 14'b00000000001000,
    ST_SUM   = 14'b00000000010000,
    ST_CHK   = 14'b00000000100000,
    ST_LHS   = 14'b00000001000000,
    ST_RSQ   = 14'b00000010000000,
    ST_RCMP  = 14'b00000100000000,
    ST_AWAIT = 14'b00001000000000,
    ST_SCL   = 14'b00010000000000,
    ST_RD    = 14'b00100000000000,
    ST_WB    = 14'b01000000000000,
    ST_OUT   = 14'b10000000000000
  } st_t;

  st_t                    state_r, state_nxt;
  logic signed [23:0]     center_x_r, center_y_r;
  logic [22:0]            max_radius_r;
  logic [6:0]             sector_count_r;
  logic [5:0]             ring_count_r;
  logic [NS_W-1:0]        ns;
  logic [NR_W-1:0]        nr;

  logic                   func_r;
  logic signed [24:0]     dx_r, dy_r;
  logic signed [23:0]     z_r;
  logic [49:0]            dxx_r, dyy_r, d2_r;
  logic [45:0]            mm_r;
  logic [55:0]            lhs1_r;
  logic [61:0]            lhs_r;
  logic [55:0]            sq_r;
  logic [27:0]            km_r;
  logic [NR_W-1:0]        k_r;
  logic [SEC_W-1:0]       sec_r;
  logic [RING_W-1:0]      ring_r;
  logic [ANGLE_BITS+NS_W:0] prod_r;
  logic [1:0]             stat_r;
  logic [H_W-1:0]         h_r;
  logic [ADDR_W-1:0]      clr_r;

  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic [5:0]             out_sector_r;
  logic [4:0]             out_ring_r;
  logic [22:0]            out_height_r;

  logic                   ram_we, ram_re;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [H_W-1:0]         ram_wdata, ram_rdata, newh;
  logic                   cordic_start;
  pmhb_ang_t              ang;
  logic                   in_xfer, out_free;
  logic signed [24:0]     dx_in, dy_in;
  logic [NS_W:0]          sec_full;

  assign ns = (sector_count_r == 7'd0) ? NS_W'(1) :
              ((sector_count_r > 7'(MAX_SECTORS)) ? NS_W'(MAX_SECTORS) : NS_W'(sector_count_r));
  assign nr = (ring_count_r == 6'd0) ? NR_W'(1) :
              ((ring_count_r > 6'(MAX_RINGS)) ? NR_W'(MAX_RINGS) : NR_W'(ring_count_r));

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign dx_in     = 25'(in_point_x) - 25'(center_x_r);
  assign dy_in     = 25'(in_point_y) - 25'(center_y_r);
  assign sec_full  = prod_r[ANGLE_BITS+NS_W : ANGLE_BITS];

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_cell_sector = out_sector_r;
  assign out_cell_ring   = out_ring_r;
  assign out_cell_height = out_height_r;

  // bin keeps the larger of stored and positive point height; read clears
  assign newh = (!z_r[23] && z_r[22:0] > ram_rdata) ? z_r[22:0] : ram_rdata;

  assign ram_re       = (state_r == ST_RD);
  assign ram_raddr    = {sec_r, ring_r};
  assign ram_we       = (state_r == ST_CLR) || (state_r == ST_WB);
  assign ram_waddr    = (state_r == ST_CLR) ? clr_r : {sec_r, ring_r};
  assign ram_wdata    = (state_r == ST_CLR || func_r) ? '0 : newh;
  assign cordic_start = (state_r == ST_CHK) && !(d2_r < 50'd100 || d2_r > 50'(mm_r));

  pmhb_ram #(.WIDTH(H_W), .DEPTH(DEPTH)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pmhb_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .dx    (dx_r),
    .dy    (dy_r),
    .ang   (ang)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLR:   if (clr_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_xfer) state_nxt = in_func ? ST_RDCHK : ST_SQ;
      ST_RDCHK: state_nxt = (stat_r == STAT_OOR) ? ST_OUT : ST_RD;
      ST_SQ:    state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_CHK;
      ST_CHK:   state_nxt = cordic_start ? ST_LHS : ST_OUT;
      ST_LHS:   state_nxt = ST_RSQ;
      ST_RSQ:   state_nxt = (k_r >= nr) ? ST_AWAIT : ST_RCMP;
      ST_RCMP:  state_nxt = ST_RSQ;
      ST_AWAIT: if (ang.done) state_nxt = ST_SCL;
      ST_SCL:   state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_WB;
      ST_WB:    state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLR;
      clr_r          <= '0;
      out_valid_r    <= 1'b0;
      center_x_r     <= '0;
      center_y_r     <= '0;
      max_radius_r   <= 23'd80000;
      sector_count_r <= 7'd60;
      ring_count_r   <= 6'd20;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CENTER_X:     center_x_r     <= cfg_data;
          CFG_CENTER_Y:     center_y_r     <= cfg_data;
          CFG_MAX_RADIUS:   max_radius_r   <= cfg_data[22:0];
          CFG_SECTOR_COUNT: sector_count_r <= cfg_data[6:0];
          CFG_RING_COUNT:   ring_count_r   <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        func_r <= in_func;
        dx_r   <= dx_in;
        dy_r   <= dy_in;
        z_r    <= in_point_z;
        sec_r  <= in_read_sector[SEC_W-1:0];
        ring_r <= in_read_ring[RING_W-1:0];
        stat_r <= (7'(in_read_sector) >= 7'(ns) || 6'(in_read_ring) >= 6'(nr)) ?
                  STAT_OOR : STAT_READ;
        h_r    <= '0;
      end
      ST_RDCHK: begin
        if (stat_r == STAT_OOR) begin
          sec_r  <= '0;
          ring_r <= '0;
        end
      end
      ST_SQ: begin
        dxx_r <= unsigned'(50'(dx_r) * 50'(dx_r));
        dyy_r <= unsigned'(50'(dy_r) * 50'(dy_r));
        mm_r  <= max_radius_r * max_radius_r;
      end
      ST_SUM: d2_r <= dxx_r + dyy_r;
      ST_CHK: begin
        lhs1_r <= d2_r * 56'(nr);
        k_r    <= NR_W'(1);
        km_r   <= 28'(max_radius_r);
        sec_r  <= '0;
        ring_r <= '0;
        stat_r <= cordic_start ? STAT_BIN : STAT_DROP;
      end
      ST_LHS:  lhs_r <= lhs1_r * 62'(nr);
      ST_RSQ:  sq_r  <= km_r * km_r;
      ST_RCMP: begin
        if (62'(sq_r) <= lhs_r) begin
          ring_r <= RING_W'(k_r);
        end
        k_r  <= k_r + 1'b1;
        km_r <= km_r + 28'(max_radius_r);
      end
      ST_AWAIT: prod_r <= ang.angle * (ANGLE_BITS+NS_W+1)'(ns);
      ST_SCL: begin
        sec_r <= (sec_full > (NS_W+1)'(ns - 1'b1)) ?
                 SEC_W'(ns - 1'b1) : SEC_W'(sec_full);
      end
      ST_WB:   h_r <= func_r ? ram_rdata : newh;
      default: ;
    endcase
    if (state_r == ST_OUT && out_free) begin
      out_status_r <= stat_r;
      out_sector_r <= 6'(sec_r);
      out_ring_r   <= 5'(ring_r);
      out_height_r <= h_r;
    end
  end

  a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> in_stall) else $error("accept during clearing pass");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLR || state_r == ST_WB)) else $error("stray grid write");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STAT_DROP || out_status_r == STAT_OOR)) |->
    (out_height_r == '0 && out_sector_r == '0 && out_ring_r == '0))
    else $error("dropped result carries cell data");

  a_ring_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB && !func_r) |-> (NR_W'(ring_r) < nr)) else $error("ring out of range");

endmodule
`default_nettype wire

// ===== hw/rtl/pmhb_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none
module pmhb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/pmhb_cordic.sv =====
// vectoring cordic: normalizes one bit a cycle, then one rotation a cycle
// gives the rounded turn angle of (dx, dy); depends on pmhb_pkg
`default_nettype none
module pmhb_cordic (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic signed [24:0]        dx,
  input  wire logic signed [24:0]        dy,
  output pmhb_pkg::pmhb_ang_t            ang
);
  import pmhb_pkg::*;

  typedef enum logic [3:0] {
    CS_IDLE = 4'b0001,
    CS_NORM = 4'b0010,
    CS_ITER = 4'b0100,
    CS_FIN  = 4'b1000
  } cs_t;

  localparam logic signed [35:0] NORM_LIM = 36'sd1073741824;
  localparam logic signed [34:0] HALF     = 35'sd2147483648;
  localparam logic signed [34:0] FULL     = 35'sd4294967296;
  localparam logic signed [34:0] RND      = 35'sd1 <<< (31 - ANGLE_BITS);

  cs_t                      state_r, state_nxt;
  logic signed [35:0]       x_r, x_nxt, y_r, y_nxt;
  logic signed [34:0]       z_r, z_nxt;
  logic [5:0]               n_r, n_nxt;
  logic [ITER_W-1:0]        i_r, i_nxt;
  pmhb_ang_t                ang_r, ang_nxt;
  logic signed [35:0]       xs, ys;
  logic signed [34:0]       at, u, uc;
  logic [34:0]              ur;

  assign ang = ang_r;
  assign xs  = x_r >>> i_r;
  assign ys  = y_r >>> i_r;
  assign at  = signed'({3'b000, atan_turn(5'(i_r))});
  assign u   = z_r + HALF;
  assign uc  = (u < 0) ? '0 : ((u > FULL) ? FULL : u);
  assign ur  = unsigned'(uc + RND);

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    ang_nxt   = ang_r;
    case (state_r)
      CS_IDLE: begin
        if (start) begin
          ang_nxt.done = 1'b0;
          n_nxt        = '0;
          i_nxt        = '0;
          if (dx < 0) begin
            x_nxt = -36'(dx);
            y_nxt = -36'(dy);
            z_nxt = (dy >= 0) ? HALF : -HALF;
          end else begin
            x_nxt = 36'(dx);
            y_nxt = 36'(dy);
            z_nxt = '0;
          end
          state_nxt = CS_NORM;
        end
      end
      CS_NORM: begin
        if (x_r < NORM_LIM && y_r < NORM_LIM && y_r > -NORM_LIM && n_r < 6'd40) begin
          x_nxt = x_r <<< 1;
          y_nxt = y_r <<< 1;
          n_nxt = n_r + 6'd1;
        end else begin
          state_nxt = CS_ITER;
        end
      end
      CS_ITER: begin
        if (y_r >= 0) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + at;
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - at;
        end
        i_nxt = i_r + 1'b1;
        if (i_r == ITER_W'(ANGLE_BITS - 1)) begin
          state_nxt = CS_FIN;
        end
      end
      CS_FIN: begin
        ang_nxt.angle = ur[32 -: (ANGLE_BITS + 1)];
        ang_nxt.done  = 1'b1;
        state_nxt     = CS_IDLE;
      end
      default: state_nxt = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= CS_IDLE;
      ang_r.done <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ang_r.done <= ang_nxt.done;
    end
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    z_r         <= z_nxt;
    n_r         <= n_nxt;
    i_r         <= i_nxt;
    ang_r.angle <= ang_nxt.angle;
  end
endmodule
`default_nettype wire

// ===== sim/tb_polar_max_height_binner_unit.sv =====
// self-checking testbench for polar_max_height_binner_unit: directed and random points
// and cell reads against an in-bench predictor of the polar grid; uses pmhb_pkg
`timescale 1ns / 1ps
module tb_polar_max_height_binner_unit;
  import pmhb_pkg::*;

  typedef struct {
    bit                 func;
    logic signed [23:0] x, y, z;
    logic [5:0]         rsec;
    logic [4:0]         rring;
  } grid_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [5:0]  sector;
    logic [4:0]  ring;
    logic [22:0] height;
  } cell_result_t;

  localparam longint HALF = 64'sd1 <<< 31;
  localparam longint FULL = 64'sd1 <<< 32;
  localparam longint NORM = 64'sd1 <<< 30;
  localparam int WATCHDOG_LIMIT = 12000;

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall;
  logic in_func = 0;
  logic signed [23:0] in_point_x = 0, in_point_y = 0, in_point_z = 0;
  logic [5:0] in_read_sector = 0;
  logic [4:0] in_read_ring = 0;
  logic out_valid, out_stall = 0;
  logic [1:0] out_status;
  logic [5:0] out_cell_sector;
  logic [4:0] out_cell_ring;
  logic [22:0] out_cell_height;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [23:0] cfg_data = 0;

  polar_max_height_binner_unit dut (.*);

  initial forever #2 clk = ~clk;

  // predictor state
  longint      cen_x = 0, cen_y = 0;
  longint      radius = 80000;
  int unsigned sectors = 60, rings = 20;
  logic [22:0] height_grid [DEPTH];
  logic [31:0] atan_lut [16] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                                 32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                                 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                                 32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C};

  grid_item_t   pending_items[$];
  cell_result_t expected_cells[$];
  int errors = 0;
  bit idle_on = 0;
  int hold_req = 0, hold_seen = 0;
  int gap_left = 0, stall_left = 0, quiet_cycles = 0;

  function automatic int unsigned eff_count(int unsigned c, int unsigned maxc);
    if (c == 0) return 1;
    return (c > maxc) ? maxc : c;
  endfunction

  // vectoring cordic, result rounded to ANGLE_BITS turn units
  function automatic longint turn_angle(longint dx, longint dy);
    longint x, y, z, xs, ys, u;
    int n;
    x = dx; y = dy; z = 0; n = 0;
    if (x < 0) begin
      z = (y >= 0) ? HALF : -HALF;
      x = -x;
      y = -y;
    end
    while (x < NORM && y < NORM && y > -NORM && n < 40) begin
      x = x * 2; y = y * 2; n++;
    end
    for (int i = 0; i < ANGLE_BITS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(atan_lut[i]);
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(atan_lut[i]);
      end
    end
    u = z + HALF;
    if (u < 0) u = 0;
    if (u > FULL) u = FULL;
    return (u + (64'sd1 <<< (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
  endfunction

  function automatic cell_result_t bin_or_read(grid_item_t it);
    cell_result_t r;
    int unsigned ns, nr, idx;
    longint dx, dy, d2, lhs, a, km, sec;
    ns = eff_count(sectors, MAX_SECTORS);
    nr = eff_count(rings, MAX_RINGS);
    r = '{STAT_DROP, 6'd0, 5'd0, 23'd0};
    if (it.func) begin
      if (it.rsec >= ns || it.rring >= nr) begin
        r.status = STAT_OOR;
      end else begin
        idx = it.rsec * MAX_RINGS + it.rring;
        r = '{STAT_READ, it.rsec, it.rring, height_grid[idx]};
        height_grid[idx] = 0;
      end
    end else begin
      dx = longint'(it.x) - cen_x;
      dy = longint'(it.y) - cen_y;
      d2 = dx * dx + dy * dy;
      if (d2 >= 100 && d2 <= radius * radius) begin
        lhs = d2 * nr * nr;
        r.ring = 0;
        for (int k = 1; k < nr; k++) begin
          km = k * radius;
          if (km * km <= lhs) r.ring = 5'(k);
        end
        a = turn_angle(dx, dy);
        sec = (a * ns) >>> ANGLE_BITS;
        if (sec > ns - 1) sec = ns - 1;
        r.sector = 6'(sec);
        idx = 32'(sec * MAX_RINGS + r.ring);
        if (longint'(it.z) > longint'(height_grid[idx])) height_grid[idx] = it.z[22:0];
        r.height = height_grid[idx];
        r.status = STAT_BIN;
      end
    end
    return r;
  endfunction

  task automatic queue_item(grid_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  // input side
  always @(posedge clk) begin
    grid_item_t it;
    bit free;
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      free = !in_valid || !in_stall;
      if (in_valid && !in_stall)
        expected_cells.insert(expected_cells.size(),
                              bin_or_read('{in_func, in_point_x, in_point_y, in_point_z,
                                            in_read_sector, in_read_ring}));
      if (free) begin
        if (gap_left == 0 && pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_func <= it.func;
          in_point_x <= it.x;
          in_point_y <= it.y;
          in_point_z <= it.z;
          in_read_sector <= it.rsec;
          in_read_ring <= it.rring;
          in_valid <= 1;
          gap_left <= idle_on ? $urandom_range(0, 14) : 0;
        end else begin
          in_valid <= 0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    cell_result_t e;
    int n;
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_cells.size() == 0) begin
          $display("%0t: result with nothing expected, actual status %0d sector %0d ring %0d height %0d",
                   $time, out_status, out_cell_sector, out_cell_ring, out_cell_height);
          errors++;
        end else begin
          e = expected_cells.pop_front();
          if (out_status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
            errors++;
          end
          if (out_cell_sector !== e.sector) begin
            $display("%0t: sector expected %0d actual %0d", $time, e.sector, out_cell_sector);
            errors++;
          end
          if (out_cell_ring !== e.ring) begin
            $display("%0t: ring expected %0d actual %0d", $time, e.ring, out_cell_ring);
            errors++;
          end
          if (out_cell_height !== e.height) begin
            $display("%0t: height expected %0d actual %0d", $time, e.height, out_cell_height);
            errors++;
          end
        end
      end
      if (hold_req != hold_seen) begin
        // long back-pressure so the block fills up
        hold_seen <= hold_req;
        stall_left <= 400;
        out_stall <= 1;
      end else if (out_valid && !out_stall) begin
        n = idle_on ? $urandom_range(0, 14) : 0;
        stall_left <= n;
        out_stall <= (n != 0);
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= (stall_left > 1);
      end else begin
        out_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      CFG_CENTER_X:     cen_x = longint'(signed'(val));
      CFG_CENTER_Y:     cen_y = longint'(signed'(val));
      CFG_MAX_RADIUS:   radius = val[22:0];
      CFG_SECTOR_COUNT: sectors = val[6:0];
      CFG_RING_COUNT:   rings = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [23:0] cx, logic [23:0] cy, logic [23:0] r,
                         logic [23:0] ns, logic [23:0] nr);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_MAX_RADIUS, r);
    write_reg(CFG_SECTOR_COUNT, ns);
    write_reg(CFG_RING_COUNT, nr);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_cells.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // point given relative to the current centre
  task automatic add_point(longint dx, longint dy, longint z);
    queue_item('{0, 24'(cen_x + dx), 24'(cen_y + dy), 24'(z), 6'd0, 5'd0});
  endtask

  task automatic add_read(int s, int r);
    queue_item('{1, 24'($urandom), 24'($urandom), 24'($urandom), 6'(s), 5'(r)});
  endtask

  function automatic longint rand_height();
    case ($urandom_range(0, 3))
      0: return longint'(signed'(24'($urandom)));
      1: return 8388607;
      default: return longint'($urandom_range(0, 6000)) - 1000;
    endcase
  endfunction

  task automatic random_items(int count);
    longint r;
    int ns, nr;
    ns = eff_count(sectors, MAX_SECTORS);
    nr = eff_count(rings, MAX_RINGS);
    r = (radius > 4000000) ? 4000000 : radius;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5:
          add_point(longint'($urandom_range(0, 2 * r)) - r,
                    longint'($urandom_range(0, 2 * r)) - r, rand_height());
        6, 7:
          add_read($urandom_range(0, ns - 1), $urandom_range(0, nr - 1));
        8:
          add_read($urandom_range(0, 63), $urandom_range(0, 31));
        default:
          queue_item('{1'($urandom_range(0, 1)), 24'($urandom), 24'($urandom),
                       24'($urandom), 6'($urandom), 5'($urandom)});
      endcase
    end
  endtask

  initial begin
    foreach (height_grid[i]) height_grid[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // directed cases at reset settings
    add_point(0, 0, 100);              // at the centre, dropped
    add_point(5, 5, 100);              // inside 10 mm
    add_point(10, 0, 50);              // exactly 10 mm
    add_point(-1000, 0, 300);          // half turn
    add_point(-1000, -1, 200);
    add_point(80000, 0, 8388607);      // on the outer radius
    add_point(80001, 0, 10);           // just outside
    add_point(0, 79999, -5);           // negative height
    add_point(-56000, -56000, -8388608);
    add_point(30000, -40000, 777);
    add_point(30000, -40000, 500);     // lower height keeps the maximum
    add_read(59, 19);
    add_read(60, 0);                   // sector out of range
    add_read(0, 20);                   // ring out of range
    add_read(63, 31);
    queue_item('{0, -24'sd8388608, 24'sd8388607, 24'sd1000, 6'd0, 5'd0});
    queue_item('{0, 24'sd8388607, -24'sd8388608, 24'sd1, 6'd0, 5'd0});
    for (int s = 0; s < 60; s += 7) add_read(s, $urandom_range(0, 19));
    drain();

    idle_on = 1;
    set_all(24'd5000, -24'sd3000, 24'd1000, 24'd64, 24'd32);
    add_read(0, 0);
    hold_req++;
    random_items(250);
    drain();

    idle_on = 0;
    set_all(-24'sd8388608, 24'sd8388607, 24'd8388607, 24'd0, 24'd0);
    add_point(-1000, 0, 5);
    add_read(0, 0);
    add_read(1, 0);
    random_items(200);
    drain();

    idle_on = 1;
    set_all(24'd0, 24'd0, 24'd11, 24'd1, 24'd1);
    add_point(10, 0, 7);
    add_point(-11, 0, 9);
    add_point(8, 8, 3);
    random_items(200);
    drain();

    set_all(24'd100, 24'd100, 24'd5, 24'd127, 24'd63);
    add_read(63, 31);
    random_items(150);
    drain();

    set_all(24'($urandom_range(0, 2000)) - 24'd1000, 24'($urandom_range(0, 2000)) - 24'd1000,
            24'($urandom_range(100, 200000)), 24'($urandom_range(1, 64)),
            24'($urandom_range(1, 32)));
    random_items(300);
    drain();

    idle_on = 1;
    set_all(24'd0, 24'd0, 24'd80000, 24'd60, 24'd20);
    random_items(300);
    drain();

    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/pmhb_pkg.sv
hw/rtl/pmhb_ram.sv
hw/rtl/pmhb_cordic.sv
hw/rtl/polar_max_height_binner_unit.sv
sim/tb_polar_max_height_binner_unit.sv
